FILE: rtl/core/button_debounce_axis_smoother_core_assert.svh
// Assertion macros shared by the button debounce / axis smoother RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef BUTTON_DEBOUNCE_AXIS_SMOOTHER_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_AXIS_SMOOTHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BDAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BDAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDAS_ASSERT_NOW(lbl, ante, cons, msg)
`define BDAS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/bdas_pkg.sv
// Package for the button debounce / axis smoother core: sizes, reset values,
// register indexes and the lane configuration struct. No dependencies.
package bdas_pkg;

	localparam int NUM_BUTTONS   = 4;
	localparam int RAW_BUTTONS   = 4;
	localparam int TIMED_BUTTONS = 3;

	localparam int LIMIT_W = 10;
	localparam int CNT_W   = 11;
	localparam int TIMER_W = 22;
	localparam int COEFF_W = 16;
	localparam int AXIS_W  = 16;
	localparam int FILT_W  = 24;
	localparam int WDATA_W = 22;
	localparam int INDEX_W = 3;

	localparam logic [CNT_W-1:0]   CNT_MAX            = '1;
	localparam logic [COEFF_W-1:0] COEFF_RESET        = 16'd58982;
	localparam logic [LIMIT_W-1:0] PRESS_LIMIT_RESET  = 10'd500;
	localparam logic [LIMIT_W-1:0] RELEASE_LIMIT_RESET = 10'd200;
	localparam logic [TIMER_W-1:0] HOLDOFF_RESET      = 22'd2000000;

	typedef enum logic [INDEX_W-1:0] {
		REG_DEVICE_PRESENT  = 3'd0,
		REG_SMOOTHING_COEFF = 3'd1,
		REG_PRESS_LIMIT     = 3'd2,
		REG_RELEASE_LIMIT   = 3'd3,
		REG_HOLDOFF_TICKS   = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic               device_present;
		logic [LIMIT_W-1:0] press_limit;
		logic [LIMIT_W-1:0] release_limit;
		logic [TIMER_W-1:0] holdoff_ticks;
	} lane_cfg_t;

endpackage

FILE: rtl/core/bdas_button_lane.sv
// One button lane: hold-off timer, status auto-clear and asymmetric counter debounce.
// Depends on bdas_pkg and button_debounce_axis_smoother_core_assert.svh.
`include "button_debounce_axis_smoother_core_assert.svh"

module bdas_button_lane
	import bdas_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      timed,
	input  logic      raw,
	input  lane_cfg_t cfg,
	output logic      status
);

	logic               status_q, press_q, release_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIMER_W-1:0] timer_q;

	logic               s_clr, s_n, pp_n, rp_n, rel;
	logic [CNT_W-1:0]   cnt_n;
	logic [TIMER_W-1:0] t_dec, t_n;

	always_comb begin
		t_dec = (timer_q != '0) ? timer_q - 22'd1 : timer_q;
		s_clr = status_q;
		t_n   = t_dec;
		if (timed && status_q && t_dec == '0) begin
			s_clr = 1'b0;
			t_n   = cfg.holdoff_ticks;
		end
		if (!timed) begin
			t_n = '0;
		end
		rel   = s_clr;
		s_n   = s_clr;
		cnt_n = cnt_q;
		pp_n  = press_q;
		rp_n  = release_q;
		if (cfg.device_present) begin
			if (raw == s_clr) begin
				cnt_n = '0;
				pp_n  = 1'b0;
				rp_n  = 1'b0;
			end else begin
				if (!rp_n && !pp_n) begin
					rp_n = rel;
					pp_n = !rel;
				end
				if ((rp_n && rel) || (pp_n && !rel)) begin
					if (cnt_n != CNT_MAX) cnt_n = cnt_n + 11'd1;
				end
				if ((rp_n && !rel) || (pp_n && rel)) begin
					cnt_n = '0;
					rp_n  = 1'b0;
					pp_n  = 1'b0;
				end
				if (cnt_n > {1'b0, cfg.press_limit} && pp_n) begin
					cnt_n = '0;
					pp_n  = 1'b0;
					s_n   = 1'b1;
				end
				if (cnt_n > {1'b0, cfg.release_limit} && rp_n) begin
					cnt_n = '0;
					rp_n  = 1'b0;
					s_n   = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= 1'b0;
			press_q   <= 1'b0;
			release_q <= 1'b0;
			cnt_q     <= '0;
			timer_q   <= '0;
		end else if (step) begin
			status_q  <= s_n;
			press_q   <= pp_n;
			release_q <= rp_n;
			cnt_q     <= cnt_n;
			timer_q   <= t_n;
		end
	end

	assign status = status_q;

	`BDAS_ASSERT_NEXT(a_lane_hold, !step, $stable(status_q) && $stable(cnt_q), "lane moved without a beat")
	`BDAS_ASSERT_NOW(a_lane_untimed, !timed, timer_q == '0, "untimed lane has a running timer")
	`BDAS_ASSERT_NOW(a_lane_pending, 1'b1, !(press_q && release_q), "press and release both pending")

endmodule

FILE: rtl/core/bdas_axis_lane.sv
// One axis lane: negation, Q0.16 exponential filter and Q1.15 saturating output.
// Depends on bdas_pkg.
module bdas_axis_lane
	import bdas_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     enable,
	input  logic [COEFF_W-1:0]       coeff,
	input  logic signed [AXIS_W-1:0] raw,
	output logic signed [AXIS_W-1:0] command
);

	logic signed [FILT_W-1:0] filt_q;

	logic signed [FILT_W-1:0] raw_w, x;
	logic signed [16:0]       c_s;
	logic signed [17:0]       cr_s;
	logic signed [40:0]       prod_f;
	logic signed [41:0]       prod_x;
	logic signed [42:0]       acc;
	logic signed [FILT_W:0]   rnd;
	logic signed [17:0]       v;

	assign raw_w  = {raw[AXIS_W-1], raw, 7'b0};
	assign x      = -raw_w;
	assign c_s    = $signed({1'b0, coeff});
	assign cr_s   = $signed(18'sd65536 - {2'b00, coeff});
	assign prod_f = c_s * filt_q;
	assign prod_x = cr_s * x;
	assign acc    = {{2{prod_f[40]}}, prod_f} + {prod_x[41], prod_x} + 43'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (step && enable) begin
			filt_q <= acc[39:16];
		end
	end

	assign rnd = {filt_q[FILT_W-1], filt_q} + 25'sd64;
	assign v   = rnd[FILT_W:7];

	always_comb begin
		if (v > 18'sd32767) begin
			command = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			command = 16'sh8000;
		end else begin
			command = v[AXIS_W-1:0];
		end
	end

endmodule

FILE: rtl/core/button_debounce_axis_smoother_core.sv
// Top level: config registers, button and axis lanes, and the merging output stage.
// Depends on bdas_pkg, bdas_button_lane, bdas_axis_lane and the assert header.
//
//  channel  | handshake               | fields
//  ---------+-------------------------+-----------------------------------------
//  item     | item_valid / item_stall | buttons_raw, speed_axis, steer_axis
//  result   | result_valid/result_stall| buttons_state, speed_command, steer_command
//  config   | wr_en                   | wr_index, wr_data
//
// One beat per cycle sustained unless the result side stalls. All lanes update
// their state on the item beat; the merge stage registers the result and raises
// result_valid once the output register is free. The lane state plus the output
// register hold two results, so an item is stalled only when both are occupied
// and the result side stalls. Async reset covers all state but the output data.
`include "button_debounce_axis_smoother_core_assert.svh"

module button_debounce_axis_smoother_core
	import bdas_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [RAW_BUTTONS-1:0]   buttons_raw,
	input  logic signed [AXIS_W-1:0] speed_axis,
	input  logic signed [AXIS_W-1:0] steer_axis,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [RAW_BUTTONS-1:0]   buttons_state,
	output logic signed [AXIS_W-1:0] speed_command,
	output logic signed [AXIS_W-1:0] steer_command,
	input  logic                     wr_en,
	input  logic [INDEX_W-1:0]       wr_index,
	input  logic [WDATA_W-1:0]       wr_data
);

	lane_cfg_t          cfg_q;
	logic [COEFF_W-1:0] coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_present <= 1'b1;
			cfg_q.press_limit    <= PRESS_LIMIT_RESET;
			cfg_q.release_limit  <= RELEASE_LIMIT_RESET;
			cfg_q.holdoff_ticks  <= HOLDOFF_RESET;
			coeff_q              <= COEFF_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_DEVICE_PRESENT:  cfg_q.device_present <= wr_data[0];
				REG_SMOOTHING_COEFF: coeff_q <= wr_data[COEFF_W-1:0];
				REG_PRESS_LIMIT:     cfg_q.press_limit <= wr_data[LIMIT_W-1:0];
				REG_RELEASE_LIMIT:   cfg_q.release_limit <= wr_data[LIMIT_W-1:0];
				REG_HOLDOFF_TICKS:   cfg_q.holdoff_ticks <= wr_data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	logic valid_s1, out_valid_q, accept, advance;

	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && out_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;

	logic [NUM_BUTTONS-1:0] raw_bits, lane_status;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		if (i < RAW_BUTTONS) begin : g_raw
			assign raw_bits[i] = buttons_raw[i];
		end else begin : g_zero
			assign raw_bits[i] = 1'b0;
		end
		bdas_button_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (accept),
			.timed  (i < TIMED_BUTTONS),
			.raw    (raw_bits[i]),
			.cfg    (cfg_q),
			.status (lane_status[i])
		);
	end

	logic signed [AXIS_W-1:0] speed_cmd, steer_cmd;

	bdas_axis_lane u_speed (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.enable  (cfg_q.device_present),
		.coeff   (coeff_q),
		.raw     (speed_axis),
		.command (speed_cmd)
	);

	bdas_axis_lane u_steer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.enable  (cfg_q.device_present),
		.coeff   (coeff_q),
		.raw     (steer_axis),
		.command (steer_cmd)
	);

	logic [RAW_BUTTONS-1:0] merged_state;

	for (genvar j = 0; j < RAW_BUTTONS; j++) begin : g_merge
		if (j < NUM_BUTTONS) begin : g_have
			assign merged_state[j] = lane_status[j];
		end else begin : g_none
			assign merged_state[j] = 1'b0;
		end
	end

	logic [RAW_BUTTONS-1:0]   state_q;
	logic signed [AXIS_W-1:0] speed_q, steer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_q <= merged_state;
			speed_q <= speed_cmd;
			steer_q <= steer_cmd;
		end
	end

	assign result_valid  = out_valid_q;
	assign buttons_state = state_q;
	assign speed_command = speed_q;
	assign steer_command = steer_q;

	`BDAS_ASSERT_NEXT(a_accept_s1, accept, valid_s1, "accepted beat not tracked")
	`BDAS_ASSERT_NEXT(a_s1_moves, valid_s1 && !out_valid_q, out_valid_q, "result not merged")
	`BDAS_ASSERT_NOW(a_no_false_stall, !valid_s1 || !out_valid_q, !item_stall, "stall with free slot")

endmodule

FILE: verif/bdas_tick_checker.sv
`timescale 1ns / 100ps
// Result checker for button_debounce_axis_smoother_core. It watches the item, result and register ports,
// keeps its own debounce, hold-off and filter state, and compares each result beat.
// Depends on bdas_pkg.
module bdas_tick_checker
	import bdas_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic                     item_stall,
	input  logic [RAW_BUTTONS-1:0]   buttons_raw,
	input  logic signed [AXIS_W-1:0] speed_axis,
	input  logic signed [AXIS_W-1:0] steer_axis,
	input  logic                     result_valid,
	input  logic                     result_stall,
	input  logic [RAW_BUTTONS-1:0]   buttons_state,
	input  logic signed [AXIS_W-1:0] speed_command,
	input  logic signed [AXIS_W-1:0] steer_command,
	input  logic                     wr_en,
	input  logic [INDEX_W-1:0]       wr_index,
	input  logic [WDATA_W-1:0]       wr_data,
	output int                       error_count,
	output int                       pending_results,
	output int                       presses_seen
);

	typedef struct packed {
		logic [RAW_BUTTONS-1:0]   buttons;
		logic signed [AXIS_W-1:0] speed;
		logic signed [AXIS_W-1:0] steer;
	} tick_result_t;

	tick_result_t expected_ticks[$];

	logic               cfg_present;
	logic [COEFF_W-1:0] cfg_coeff;
	logic [LIMIT_W-1:0] cfg_press;
	logic [LIMIT_W-1:0] cfg_release;
	logic [TIMER_W-1:0] cfg_holdoff;

	logic               status_q  [NUM_BUTTONS];
	logic [CNT_W-1:0]   count_q   [NUM_BUTTONS];
	logic               press_q   [NUM_BUTTONS];
	logic               release_q [NUM_BUTTONS];
	logic [TIMER_W-1:0] timer_q   [TIMED_BUTTONS];
	logic [FILT_W-1:0]  speed_q;
	logic [FILT_W-1:0]  steer_q;

	initial begin
		error_count = 0;
		presses_seen = 0;
	end

	// Q2.22 state, retention c in Q0.16, round half up
	function automatic logic [FILT_W-1:0] filter_next(logic [FILT_W-1:0] f_in,
			logic signed [AXIS_W-1:0] raw, logic [COEFF_W-1:0] coeff);
		longint f;
		longint x;
		longint c;
		longint acc;
		f = longint'($signed(f_in));
		x = -longint'(raw) * 128;
		c = longint'(coeff);
		acc = c * f + (65536 - c) * x;
		acc = (acc + 32768) >>> 16;
		return acc[FILT_W-1:0];
	endfunction

	function automatic logic signed [AXIS_W-1:0] filter_out(logic [FILT_W-1:0] f_in);
		longint v;
		v = (longint'($signed(f_in)) + 64) >>> 7;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[AXIS_W-1:0];
	endfunction

	task automatic debounce_button(input int i, input logic raw);
		logic st;
		st = status_q[i];
		if (raw == st) begin
			count_q[i] = '0;
			press_q[i] = 1'b0;
			release_q[i] = 1'b0;
			return;
		end
		if (!release_q[i] && !press_q[i]) begin
			if (!raw)
				release_q[i] = 1'b1;
			else
				press_q[i] = 1'b1;
		end
		if ((release_q[i] && !raw) || (press_q[i] && raw)) begin
			if (count_q[i] != CNT_MAX)
				count_q[i] = count_q[i] + 1'b1;
		end
		if ((release_q[i] && raw) || (press_q[i] && !raw)) begin
			count_q[i] = '0;
			release_q[i] = 1'b0;
			press_q[i] = 1'b0;
		end
		if (count_q[i] > CNT_W'(cfg_press) && press_q[i]) begin
			count_q[i] = '0;
			press_q[i] = 1'b0;
			status_q[i] = 1'b1;
		end
		if (count_q[i] > CNT_W'(cfg_release) && release_q[i]) begin
			count_q[i] = '0;
			release_q[i] = 1'b0;
			status_q[i] = 1'b0;
		end
	endtask

	task automatic advance_tick();
		tick_result_t r;
		logic raw;
		logic was;
		for (int i = 0; i < TIMED_BUTTONS; i++)
			if (timer_q[i] != '0)
				timer_q[i] = timer_q[i] - 1'b1;
		for (int i = 0; i < TIMED_BUTTONS && i < NUM_BUTTONS; i++) begin
			if (status_q[i] && timer_q[i] == '0) begin
				status_q[i] = 1'b0;
				timer_q[i] = cfg_holdoff;
			end
		end
		if (cfg_present) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				raw = (i < RAW_BUTTONS) ? buttons_raw[i] : 1'b0;
				was = status_q[i];
				debounce_button(i, raw);
				if (!was && status_q[i])
					presses_seen++;
			end
			speed_q = filter_next(speed_q, speed_axis, cfg_coeff);
			steer_q = filter_next(steer_q, steer_axis, cfg_coeff);
		end
		r.buttons = '0;
		for (int i = 0; i < NUM_BUTTONS && i < RAW_BUTTONS; i++)
			r.buttons[i] = status_q[i];
		r.speed = filter_out(speed_q);
		r.steer = filter_out(steer_q);
		expected_ticks.push_back(r);
	endtask

	task automatic check_result();
		tick_result_t r;
		if (expected_ticks.size() == 0) begin
			$error("result beat with no item outstanding");
			error_count++;
			return;
		end
		r = expected_ticks.pop_front();
		if (buttons_state !== r.buttons) begin
			$error("buttons_state: expected %h, got %h", r.buttons, buttons_state);
			error_count++;
		end
		if (speed_command !== r.speed) begin
			$error("speed_command: expected %0d, got %0d", r.speed, speed_command);
			error_count++;
		end
		if (steer_command !== r.steer) begin
			$error("steer_command: expected %0d, got %0d", r.steer, steer_command);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_present = 1'b1;
			cfg_coeff = COEFF_RESET;
			cfg_press = PRESS_LIMIT_RESET;
			cfg_release = RELEASE_LIMIT_RESET;
			cfg_holdoff = HOLDOFF_RESET;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				status_q[i] = 1'b0;
				count_q[i] = '0;
				press_q[i] = 1'b0;
				release_q[i] = 1'b0;
			end
			for (int i = 0; i < TIMED_BUTTONS; i++)
				timer_q[i] = '0;
			speed_q = '0;
			steer_q = '0;
			expected_ticks.delete();
			pending_results <= 0;
		end else begin
			if (item_valid && !item_stall)
				advance_tick();
			if (result_valid && !result_stall)
				check_result();
			if (wr_en) begin
				case (wr_index)
					REG_DEVICE_PRESENT:  cfg_present = wr_data[0];
					REG_SMOOTHING_COEFF: cfg_coeff = wr_data[COEFF_W-1:0];
					REG_PRESS_LIMIT:     cfg_press = wr_data[LIMIT_W-1:0];
					REG_RELEASE_LIMIT:   cfg_release = wr_data[LIMIT_W-1:0];
					REG_HOLDOFF_TICKS:   cfg_holdoff = wr_data[TIMER_W-1:0];
					default: ;
				endcase
			end
			pending_results <= expected_ticks.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for button_debounce_axis_smoother_core: clock, reset, register writes,
// poll-tick stimulus with random gaps and result stalls. Depends on bdas_pkg, bdas_tick_checker and the core.
module testbench;
	import bdas_pkg::*;

	localparam logic [INDEX_W-1:0] REG_UNUSED_FIRST = 3'd5;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 6;

	logic                     clk;
	logic                     arst_n        = 1'b0;
	logic                     item_valid    = 1'b0;
	logic                     item_stall;
	logic [RAW_BUTTONS-1:0]   buttons_raw   = '0;
	logic signed [AXIS_W-1:0] speed_axis    = '0;
	logic signed [AXIS_W-1:0] steer_axis    = '0;
	logic                     result_valid;
	logic                     result_stall  = 1'b0;
	logic [RAW_BUTTONS-1:0]   buttons_state;
	logic signed [AXIS_W-1:0] speed_command;
	logic signed [AXIS_W-1:0] steer_command;
	logic                     wr_en         = 1'b0;
	logic [INDEX_W-1:0]       wr_index      = '0;
	logic [WDATA_W-1:0]       wr_data       = '0;

	int error_count;
	int pending_results;
	int presses_seen;

	int items_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit no_idle = 1'b0;
	int run_scale = 4;
	logic [RAW_BUTTONS-1:0] hold_level = '0;
	int run_left [RAW_BUTTONS] = '{0, 0, 0, 0};

	logic signed [AXIS_W-1:0] corner_vals [4] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
	logic [RAW_BUTTONS-1:0] dir_buttons [20] = '{
		4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'h0, 4'h0,
		4'h0, 4'h1, 4'h0, 4'h8, 4'h0, 4'h5, 4'ha, 4'hf, 4'h0, 4'h3};

	button_debounce_axis_smoother_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.buttons_raw   (buttons_raw),
		.speed_axis    (speed_axis),
		.steer_axis    (steer_axis),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.buttons_state (buttons_state),
		.speed_command (speed_command),
		.steer_command (steer_command),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	bdas_tick_checker monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.buttons_raw     (buttons_raw),
		.speed_axis      (speed_axis),
		.steer_axis      (steer_axis),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.buttons_state   (buttons_state),
		.speed_command   (speed_command),
		.steer_command   (steer_command),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.error_count     (error_count),
		.pending_results (pending_results),
		.presses_seen    (presses_seen)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [AXIS_W-1:0] pick_axis();
		int r;
		logic [31:0] u;
		r = $urandom_range(0, 99);
		u = $urandom;
		if (r < 16)
			return corner_vals[r % 4];
		return u[AXIS_W-1:0];
	endfunction

	// levels held for runs around the debounce limits, with some single-tick glitches
	function automatic logic [RAW_BUTTONS-1:0] next_buttons();
		logic [RAW_BUTTONS-1:0] b;
		for (int i = 0; i < RAW_BUTTONS; i++) begin
			if (run_left[i] == 0) begin
				hold_level[i] = ~hold_level[i];
				run_left[i] = $urandom_range(1, run_scale * 2 + 4);
			end
			run_left[i]--;
		end
		b = hold_level;
		if ($urandom_range(0, 99) < 12)
			b[$urandom_range(0, RAW_BUTTONS - 1)] ^= 1'b1;
		return b;
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 20)
				stall_left = 1 + pick_gap();
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", idle_cycles);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [RAW_BUTTONS-1:0] b, input logic signed [AXIS_W-1:0] s,
			input logic signed [AXIS_W-1:0] t);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		buttons_raw <= b;
		speed_axis <= s;
		steer_axis <= t;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [WDATA_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
	endtask

	task automatic configure(input int present, input int coeff, input int press_lim,
			input int release_lim, input int holdoff);
		int widest;
		settle();
		write_reg(REG_DEVICE_PRESENT, WDATA_W'(present));
		write_reg(REG_SMOOTHING_COEFF, WDATA_W'(coeff));
		write_reg(REG_PRESS_LIMIT, WDATA_W'(press_lim));
		write_reg(REG_RELEASE_LIMIT, WDATA_W'(release_lim));
		write_reg(REG_HOLDOFF_TICKS, WDATA_W'(holdoff));
		write_reg(REG_UNUSED_FIRST + INDEX_W'($urandom_range(0, 2)), WDATA_W'($urandom));
		wr_en <= 1'b0;
		widest = (press_lim > release_lim) ? press_lim : release_lim;
		run_scale = (widest + 1 > 40) ? 40 : widest + 1;
		settings_used++;
	endtask

	task automatic run_phase(input int n, input bit quiet, input bit squeeze);
		no_idle = quiet;
		for (int k = 0; k < n; k++) begin
			if (squeeze && k == n / 2)
				settle();
			send_item(next_buttons(), pick_axis(), pick_axis());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values first
		send_item(4'h0, -16'sd32768, 16'sd32767);
		send_item(4'hf, 16'sd32767, -16'sd32768);

		// short limits and hold-off so presses, auto-clears and reversals show up quickly
		configure(1, 0, 2, 1, 3);
		for (int k = 0; k < 20; k++)
			send_item(dir_buttons[k], corner_vals[k % 4], corner_vals[(k + 1) % 4]);

		configure(1, 0, 0, 0, 0);
		run_phase(150, 1'b0, 1'b0);
		configure(1, 65535, 3, 5, 7);
		run_phase(200, 1'b1, 1'b0);
		configure(0, 30000, 2, 2, 2);
		run_phase(150, 1'b0, 1'b0);
		configure(1, $urandom_range(0, 65535), $urandom_range(0, 8), $urandom_range(0, 8),
			$urandom_range(0, 30));
		run_phase(250, 1'b0, 1'b1);
		configure(1, 58982, 1023, 1023, 4194303);
		run_phase(150, 1'b0, 1'b0);
		configure(1, $urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 4194303));
		run_phase(200, 1'b0, 1'b0);
		configure(1, 1, 4, 0, 1);
		run_phase(200, 1'b1, 1'b0);
		configure(1, $urandom_range(0, 65535), $urandom_range(0, 6), $urandom_range(0, 6),
			$urandom_range(0, 10));
		run_phase(250, 1'b0, 1'b0);

		settle();
		$display("testbench: %0d item beats under %0d register settings, %0d presses debounced",
			items_sent, settings_used, presses_seen);
		$display("testbench: device absent and present, retention 0 to 65535, hold-off 0 to max");
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bdas_pkg.sv
rtl/core/bdas_button_lane.sv
rtl/core/bdas_axis_lane.sv
rtl/core/button_debounce_axis_smoother_core.sv
verif/bdas_tick_checker.sv
verif/testbench.sv
